[src/cubehash_digest_engine_assert.svh]
// ----------------------------------------------------------------------------
// CubeHash digest engine assertion macros
// Shorthand for the concurrent checks of the engine, sampled on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CUBEHASH_DIGEST_ENGINE_ASSERT_SVH
`define CUBEHASH_DIGEST_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHDE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/chde_pkg.sv]
// ----------------------------------------------------------------------------
// CubeHash digest engine package
// Shared types, constants and the round function of the engine.
// ----------------------------------------------------------------------------
`default_nettype none

package chde_pkg;

  localparam int ROT_A = 7;
  localparam int ROT_B = 11;

  localparam logic [7:0]  PAD_BYTE   = 8'h80;
  localparam logic [31:0] FINAL_FLAG = 32'h0000_0001;

  localparam logic [7:0] RST_INIT_ROUNDS      = 8'd16;
  localparam logic [7:0] RST_ROUNDS_PER_BLOCK = 8'd16;
  localparam logic [7:0] RST_BLOCK_BYTES      = 8'd32;
  localparam logic [7:0] RST_FINAL_ROUNDS     = 8'd32;
  localparam logic [6:0] RST_HASH_BYTES       = 7'd64;

  localparam int REG_IDX_W  = 3;
  localparam int REG_DATA_W = 8;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_INIT_ROUNDS      = 3'd0,
    REG_ROUNDS_PER_BLOCK = 3'd1,
    REG_BLOCK_BYTES      = 3'd2,
    REG_FINAL_ROUNDS     = 3'd3,
    REG_HASH_BYTES       = 3'd4
  } chde_reg_idx_t;

  typedef enum logic {
    OP_ABSORB = 1'b0,
    OP_FINISH = 1'b1
  } chde_op_t;

  typedef struct packed {
    chde_op_t   op;
    logic [7:0] data;
  } chde_item_t;

  typedef struct packed {
    logic       push;
    chde_item_t item;
  } chde_qpush_t;

  typedef struct packed {
    logic       valid;
    chde_item_t item;
  } chde_qhead_t;

  typedef struct packed {
    logic [7:0] init_rounds;
    logic [7:0] rounds_per_block;
    logic [7:0] final_rounds;
    logic [7:0] block_len;
    logic [6:0] digest_len;
    logic       reinit;
  } chde_cfg_t;

  typedef enum logic [2:0] {
    ST_IV,
    ST_INIT_RND,
    ST_IDLE,
    ST_BLK_RND,
    ST_FIN_RND,
    ST_FINAL_RND,
    ST_EMIT
  } chde_state_t;

  typedef logic [31:0] chde_cube_t [32];

  function automatic logic [31:0] chde_rotl(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic chde_cube_t chde_round(input chde_cube_t c);
    chde_cube_t  x;
    logic [31:0] t;
    x = c;
    for (int k = 0; k < 16; k++) begin
      x[16+k] = x[16+k] + x[k];
      x[k]    = chde_rotl(x[k], ROT_A);
    end
    for (int k = 0; k < 8; k++) begin
      t      = x[k];
      x[k]   = x[k+8];
      x[k+8] = t;
    end
    for (int k = 0; k < 16; k++) begin
      x[k] = x[k] ^ x[16+k];
    end
    for (int k = 16; k < 32; k++) begin
      if ((k & 2) == 0) begin
        t      = x[k];
        x[k]   = x[k+2];
        x[k+2] = t;
      end
    end
    for (int k = 0; k < 16; k++) begin
      x[16+k] = x[16+k] + x[k];
      x[k]    = chde_rotl(x[k], ROT_B);
    end
    for (int k = 0; k < 16; k++) begin
      if ((k & 4) == 0) begin
        t      = x[k];
        x[k]   = x[k+4];
        x[k+4] = t;
      end
    end
    for (int k = 0; k < 16; k++) begin
      x[k] = x[k] ^ x[16+k];
    end
    for (int k = 16; k < 32; k++) begin
      if ((k & 1) == 0) begin
        t      = x[k];
        x[k]   = x[k+1];
        x[k+1] = t;
      end
    end
    return x;
  endfunction

  // Moves the whole cube down by one byte so that the next digest byte
  // lands in the low byte of word 0.
  function automatic chde_cube_t chde_shift_out(input chde_cube_t c);
    chde_cube_t y;
    for (int k = 0; k < 31; k++) begin
      y[k] = {c[k+1][7:0], c[k][31:8]};
    end
    y[31] = {8'h00, c[31][31:8]};
    return y;
  endfunction

endpackage

`default_nettype wire

[src/chde_if.sv]
// ----------------------------------------------------------------------------
// CubeHash digest engine channels
// Valid/ready channels for message items and digest items.
// ----------------------------------------------------------------------------
`default_nettype none

interface chde_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface chde_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] digest_byte;
  logic       last_byte;

  modport source (output valid, output digest_byte, output last_byte, input ready);
  modport sink   (input valid, input digest_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[src/cubehash_digest_engine.sv]
// ----------------------------------------------------------------------------
// CubeHash digest engine
// Configurable CubeHash with byte-wide message input and digest output.
// ----------------------------------------------------------------------------
// Message bytes enter through a one-item front register and a four-item
// queue, so input is taken while the core runs rounds or streams a digest.
// An item passes through the front register and the queue memory before it
// reaches the core. The core applies one CubeHash round per cycle. The byte
// that fills a block starts rounds_per_block rounds. A finish item absorbs the
// pad byte, runs rounds_per_block rounds, XORs the final flag into word 31 and
// runs final_rounds rounds; the core then streams the digest bytes while the
// output is ready and rebuilds the cube with init_rounds rounds. A write to
// one of the five registers also rebuilds the cube and drops any partial
// message.
`default_nettype none

`include "cubehash_digest_engine_assert.svh"

module cubehash_digest_engine #(
  parameter int MAX_BLOCK_BYTES  = 128,
  parameter int MAX_DIGEST_BYTES = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  chde_in_if.sink                             in_ch,
  chde_out_if.source                          out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [chde_pkg::REG_IDX_W-1:0]  cfg_index,
  input  wire logic [chde_pkg::REG_DATA_W-1:0] cfg_wdata
);

  chde_pkg::chde_cfg_t   cfg;
  chde_pkg::chde_qpush_t q_push;
  chde_pkg::chde_qhead_t q_head;
  logic                  q_full;
  logic                  q_pop;

  chde_regs #(
    .MAX_BLOCK_BYTES  (MAX_BLOCK_BYTES),
    .MAX_DIGEST_BYTES (MAX_DIGEST_BYTES)
  ) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  chde_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_port (in_ch),
    .q_full  (q_full),
    .qpush   (q_push)
  );

  chde_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .qpush  (q_push),
    .q_full (q_full),
    .q_pop  (q_pop),
    .qhead  (q_head)
  );

  chde_back #(
    .MAX_BLOCK_BYTES  (MAX_BLOCK_BYTES),
    .MAX_DIGEST_BYTES (MAX_DIGEST_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .qhead    (q_head),
    .q_pop    (q_pop),
    .out_port (out_ch)
  );

  `CHDE_ASSERT_NOW(a_pop_not_empty, q_pop, q_head.valid, "queue popped while empty")
  `CHDE_ASSERT_NOW(a_push_not_full, q_push.push, !q_full, "queue pushed while full")
  `CHDE_ASSERT_NOW(a_emit_no_pop, out_ch.valid, !q_pop, "item taken during digest output")
  `CHDE_ASSERT_NEXT(a_cfg_restart, cfg_we && (cfg_index <= chde_pkg::REG_HASH_BYTES), cfg.reinit, "register write did not restart the cube")

endmodule

`default_nettype wire

[src/chde_regs.sv]
// ----------------------------------------------------------------------------
// CubeHash digest engine configuration registers
// Holds the five registers, derives the clamped lengths and flags a restart.
// ----------------------------------------------------------------------------
`default_nettype none

module chde_regs #(
  parameter int MAX_BLOCK_BYTES  = 128,
  parameter int MAX_DIGEST_BYTES = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [chde_pkg::REG_IDX_W-1:0]  cfg_index,
  input  wire logic [chde_pkg::REG_DATA_W-1:0] cfg_wdata,
  output chde_pkg::chde_cfg_t                 cfg
);

  logic [7:0] init_rounds_r;
  logic [7:0] rounds_per_block_r;
  logic [7:0] block_bytes_r;
  logic [7:0] final_rounds_r;
  logic [6:0] hash_bytes_r;
  logic       reinit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_rounds_r      <= chde_pkg::RST_INIT_ROUNDS;
      rounds_per_block_r <= chde_pkg::RST_ROUNDS_PER_BLOCK;
      block_bytes_r      <= chde_pkg::RST_BLOCK_BYTES;
      final_rounds_r     <= chde_pkg::RST_FINAL_ROUNDS;
      hash_bytes_r       <= chde_pkg::RST_HASH_BYTES;
      reinit_r           <= 1'b0;
    end else begin
      reinit_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          chde_pkg::REG_INIT_ROUNDS: begin
            init_rounds_r <= cfg_wdata;
            reinit_r      <= 1'b1;
          end
          chde_pkg::REG_ROUNDS_PER_BLOCK: begin
            rounds_per_block_r <= cfg_wdata;
            reinit_r           <= 1'b1;
          end
          chde_pkg::REG_BLOCK_BYTES: begin
            block_bytes_r <= cfg_wdata;
            reinit_r      <= 1'b1;
          end
          chde_pkg::REG_FINAL_ROUNDS: begin
            final_rounds_r <= cfg_wdata;
            reinit_r       <= 1'b1;
          end
          chde_pkg::REG_HASH_BYTES: begin
            hash_bytes_r <= cfg_wdata[6:0];
            reinit_r     <= 1'b1;
          end
          default: begin
            reinit_r <= 1'b0;
          end
        endcase
      end
    end
  end

  always_comb begin
    cfg.init_rounds      = init_rounds_r;
    cfg.rounds_per_block = rounds_per_block_r;
    cfg.final_rounds     = final_rounds_r;
    cfg.reinit           = reinit_r;
    if (block_bytes_r == 8'd0) begin
      cfg.block_len = 8'd1;
    end else if (block_bytes_r > 8'(MAX_BLOCK_BYTES)) begin
      cfg.block_len = 8'(MAX_BLOCK_BYTES);
    end else begin
      cfg.block_len = block_bytes_r;
    end
    if (hash_bytes_r == 7'd0) begin
      cfg.digest_len = 7'd1;
    end else if (hash_bytes_r > 7'(MAX_DIGEST_BYTES)) begin
      cfg.digest_len = 7'(MAX_DIGEST_BYTES);
    end else begin
      cfg.digest_len = hash_bytes_r;
    end
  end

endmodule

`default_nettype wire

[src/chde_front.sv]
// ----------------------------------------------------------------------------
// CubeHash digest engine front end
// Accepts input items, classifies them and hands them to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module chde_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  chde_in_if.sink             in_port,
  input  wire logic           q_full,
  output chde_pkg::chde_qpush_t qpush
);

  logic                 hold_valid_r;
  chde_pkg::chde_item_t hold_item_r;
  chde_pkg::chde_item_t item_nxt;
  logic                 push;
  logic                 take;

  assign push            = hold_valid_r && !q_full;
  assign in_port.ready   = !hold_valid_r || !q_full;
  assign take            = in_port.valid && in_port.ready;
  assign qpush.push      = push;
  assign qpush.item      = hold_item_r;

  always_comb begin
    if (in_port.command) begin
      item_nxt.op   = chde_pkg::OP_FINISH;
      item_nxt.data = chde_pkg::PAD_BYTE;
    end else begin
      item_nxt.op   = chde_pkg::OP_ABSORB;
      item_nxt.data = in_port.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (take) begin
      hold_valid_r <= 1'b1;
    end else if (push) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

[src/chde_fifo.sv]
// ----------------------------------------------------------------------------
// CubeHash digest engine item queue
// Short queue of classified items between the front end and the core.
// ----------------------------------------------------------------------------
`default_nettype none

module chde_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire chde_pkg::chde_qpush_t qpush,
  output logic                 q_full,
  input  wire logic            q_pop,
  output chde_pkg::chde_qhead_t qhead
);

  chde_pkg::chde_item_t         mem [chde_pkg::Q_DEPTH];
  logic [chde_pkg::Q_AW-1:0]    wr_ptr_r;
  logic [chde_pkg::Q_AW-1:0]    rd_ptr_r;
  logic [chde_pkg::Q_AW:0]      count_r;

  assign q_full      = count_r == (chde_pkg::Q_AW + 1)'(chde_pkg::Q_DEPTH);
  assign qhead.valid = count_r != '0;
  assign qhead.item  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (qpush.push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({qpush.push, q_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (qpush.push) begin
      mem[wr_ptr_r] <= qpush.item;
    end
  end

endmodule

`default_nettype wire

[src/chde_back.sv]
// ----------------------------------------------------------------------------
// CubeHash digest engine core
// Holds the cube, absorbs message items, runs one round per cycle and streams out the digest.
// ----------------------------------------------------------------------------
`default_nettype none

module chde_back #(
  parameter int MAX_BLOCK_BYTES  = 128,
  parameter int MAX_DIGEST_BYTES = 64
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire chde_pkg::chde_cfg_t   cfg,
  input  wire chde_pkg::chde_qhead_t qhead,
  output logic                 q_pop,
  chde_out_if.source           out_port
);

  localparam int POS_W = (MAX_BLOCK_BYTES > 1) ? $clog2(MAX_BLOCK_BYTES) : 1;
  localparam int CNT_W = (MAX_DIGEST_BYTES > 1) ? $clog2(MAX_DIGEST_BYTES) : 1;

  chde_pkg::chde_state_t state_r, state_nxt;
  chde_pkg::chde_cube_t  cube_r, cube_nxt, rounded;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [7:0]            rounds_left_r, rounds_left_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [6:0]            byte_idx;
  logic [4:0]            wsel;
  logic [1:0]            lane;
  logic [7:0]            pos_inc;
  logic                  last;
  logic                  out_valid;

  assign byte_idx = 7'(pos_r);
  assign wsel     = byte_idx[6:2];
  assign lane     = byte_idx[1:0];
  assign pos_inc  = 8'(pos_r) + 8'd1;
  assign last     = (7'(cnt_r) + 7'd1) == cfg.digest_len;

  assign out_port.valid       = out_valid;
  assign out_port.digest_byte = cube_r[0][7:0];
  assign out_port.last_byte   = last;

  always_comb begin
    rounded = chde_pkg::chde_round(cube_r);
  end

  always_comb begin
    state_nxt       = state_r;
    cube_nxt        = cube_r;
    pos_nxt         = pos_r;
    rounds_left_nxt = rounds_left_r;
    cnt_nxt         = cnt_r;
    q_pop           = 1'b0;
    out_valid       = 1'b0;
    case (state_r)
      chde_pkg::ST_IV: begin
        cube_nxt        = '{default: '0};
        cube_nxt[0]     = 32'(cfg.digest_len);
        cube_nxt[1]     = 32'(cfg.block_len);
        cube_nxt[2]     = 32'(cfg.rounds_per_block);
        pos_nxt         = '0;
        rounds_left_nxt = cfg.init_rounds;
        state_nxt       = chde_pkg::ST_INIT_RND;
      end
      chde_pkg::ST_INIT_RND, chde_pkg::ST_BLK_RND: begin
        if (rounds_left_r != 8'd0) begin
          cube_nxt        = rounded;
          rounds_left_nxt = rounds_left_r - 8'd1;
        end else begin
          state_nxt = chde_pkg::ST_IDLE;
        end
      end
      chde_pkg::ST_IDLE: begin
        if (qhead.valid) begin
          q_pop          = 1'b1;
          cube_nxt[wsel] = cube_r[wsel] ^ (32'(qhead.item.data) << {lane, 3'b000});
          if (qhead.item.op == chde_pkg::OP_FINISH) begin
            rounds_left_nxt = cfg.rounds_per_block;
            state_nxt       = chde_pkg::ST_FIN_RND;
          end else if (pos_inc >= cfg.block_len) begin
            pos_nxt         = '0;
            rounds_left_nxt = cfg.rounds_per_block;
            state_nxt       = chde_pkg::ST_BLK_RND;
          end else begin
            pos_nxt = pos_inc[POS_W-1:0];
          end
        end
      end
      chde_pkg::ST_FIN_RND: begin
        if (rounds_left_r != 8'd0) begin
          cube_nxt        = rounded;
          rounds_left_nxt = rounds_left_r - 8'd1;
        end else begin
          cube_nxt[31]    = cube_r[31] ^ chde_pkg::FINAL_FLAG;
          rounds_left_nxt = cfg.final_rounds;
          state_nxt       = chde_pkg::ST_FINAL_RND;
        end
      end
      chde_pkg::ST_FINAL_RND: begin
        if (rounds_left_r != 8'd0) begin
          cube_nxt        = rounded;
          rounds_left_nxt = rounds_left_r - 8'd1;
        end else begin
          cnt_nxt   = '0;
          state_nxt = chde_pkg::ST_EMIT;
        end
      end
      chde_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_port.ready) begin
          cube_nxt = chde_pkg::chde_shift_out(cube_r);
          cnt_nxt  = cnt_r + 1'b1;
          if (last) begin
            state_nxt = chde_pkg::ST_IV;
          end
        end
      end
      default: begin
        state_nxt = chde_pkg::ST_IV;
      end
    endcase
    if (cfg.reinit) begin
      state_nxt = chde_pkg::ST_IV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= chde_pkg::ST_IV;
      pos_r         <= '0;
      rounds_left_r <= '0;
      cnt_r         <= '0;
    end else begin
      state_r       <= state_nxt;
      pos_r         <= pos_nxt;
      rounds_left_r <= rounds_left_nxt;
      cnt_r         <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cube_r <= cube_nxt;
  end

endmodule

`default_nettype wire

[tb/cubehash_digest_engine_checker.sv]
// ----------------------------------------------------------------------------
// CubeHash digest engine checker
// Watches the message, digest and register ports of the engine. It keeps
// its own copy of the cube and the settings and works out the digest bytes
// that each finish item must produce. It compares every digest item with
// the oldest outstanding byte and reports the mismatch count to the bench.
// ----------------------------------------------------------------------------
module cubehash_digest_engine_checker
  import chde_pkg::*;
#(
  parameter int MAX_BLOCK_BYTES  = 128,
  parameter int MAX_DIGEST_BYTES = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_command,
  input  logic [7:0]            in_data_byte,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [7:0]            out_digest_byte,
  input  logic                  out_last_byte,
  input  logic                  cfg_we,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [REG_DATA_W-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    expected_left,
  output int                    digests_done
);

  typedef struct packed {
    logic [7:0] digest_byte;
    logic       last_byte;
  } digest_item_t;

  logic [31:0]  cube [32];
  logic [7:0]   init_rounds;
  logic [7:0]   block_rounds;
  logic [7:0]   block_len;
  logic [7:0]   final_rounds;
  logic [6:0]   digest_len;
  int unsigned  fill;
  digest_item_t digest_queue [$];
  int           fail_total = 0;
  int           digest_total = 0;

  function automatic logic [31:0] rot_left(logic [31:0] v, int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  task automatic exchange(int a, int b);
    logic [31:0] t;
    t       = cube[a];
    cube[a] = cube[b];
    cube[b] = t;
  endtask

  task automatic cube_round();
    for (int k = 0; k < 16; k++) begin
      cube[16+k] = cube[16+k] + cube[k];
      cube[k]    = rot_left(cube[k], ROT_A);
    end
    for (int k = 0; k < 8; k++) exchange(k, k + 8);
    for (int k = 0; k < 16; k++) cube[k] = cube[k] ^ cube[16+k];
    for (int k = 16; k < 32; k++) begin
      if ((k & 2) == 0) exchange(k, k + 2);
    end
    for (int k = 0; k < 16; k++) begin
      cube[16+k] = cube[16+k] + cube[k];
      cube[k]    = rot_left(cube[k], ROT_B);
    end
    for (int k = 0; k < 16; k++) begin
      if ((k & 4) == 0) exchange(k, k + 4);
    end
    for (int k = 0; k < 16; k++) cube[k] = cube[k] ^ cube[16+k];
    for (int k = 16; k < 32; k++) begin
      if ((k & 1) == 0) exchange(k, k + 1);
    end
  endtask

  task automatic run_rounds(int unsigned n);
    repeat (n) cube_round();
  endtask

  function automatic int unsigned block_len_eff();
    if (block_len == 0) return 1;
    if (block_len > MAX_BLOCK_BYTES) return MAX_BLOCK_BYTES;
    return block_len;
  endfunction

  function automatic int unsigned digest_len_eff();
    if (digest_len == 0) return 1;
    if (digest_len > MAX_DIGEST_BYTES) return MAX_DIGEST_BYTES;
    return digest_len;
  endfunction

  task automatic rebuild_cube();
    foreach (cube[k]) cube[k] = '0;
    cube[0] = digest_len_eff();
    cube[1] = block_len_eff();
    cube[2] = 32'(block_rounds);
    fill    = 0;
    run_rounds(init_rounds);
  endtask

  task automatic mix_in(int unsigned pos, logic [7:0] b);
    cube[pos >> 2] = cube[pos >> 2] ^ (32'(b) << (8 * (pos % 4)));
  endtask

  task automatic hash_item(chde_op_t op, logic [7:0] b);
    digest_item_t e;
    int unsigned  n;
    if (fill >= block_len_eff()) fill = 0;
    if (op == OP_ABSORB) begin
      mix_in(fill, b);
      fill++;
      if (fill >= block_len_eff()) begin
        run_rounds(block_rounds);
        fill = 0;
      end
    end else begin
      mix_in(fill, PAD_BYTE);
      run_rounds(block_rounds);
      cube[31] = cube[31] ^ FINAL_FLAG;
      run_rounds(final_rounds);
      n = digest_len_eff();
      for (int unsigned k = 0; k < n; k++) begin
        e.digest_byte = 8'(cube[k >> 2] >> (8 * (k % 4)));
        e.last_byte   = (k + 1 == n);
        digest_queue.push_back(e);
      end
      rebuild_cube();
    end
  endtask

  always @(posedge clk) begin
    digest_item_t head;
    logic         hit;
    if (!rst_n) begin
      init_rounds  = RST_INIT_ROUNDS;
      block_rounds = RST_ROUNDS_PER_BLOCK;
      block_len    = RST_BLOCK_BYTES;
      final_rounds = RST_FINAL_ROUNDS;
      digest_len   = RST_HASH_BYTES;
      rebuild_cube();
      digest_queue.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (digest_queue.size() == 0) begin
          $error("digest item with nothing expected: digest_byte %02h, last_byte %0b",
                 out_digest_byte, out_last_byte);
          fail_total++;
        end else begin
          head = digest_queue.pop_front();
          if (out_digest_byte !== head.digest_byte) begin
            $error("digest_byte mismatch: expected %02h, actual %02h",
                   head.digest_byte, out_digest_byte);
            fail_total++;
          end
          if (out_last_byte !== head.last_byte) begin
            $error("last_byte mismatch: expected %0b, actual %0b",
                   head.last_byte, out_last_byte);
            fail_total++;
          end
          if (head.last_byte) digest_total++;
        end
      end
      if (cfg_we) begin
        hit = 1'b1;
        case (cfg_index)
          REG_INIT_ROUNDS:      init_rounds  = cfg_wdata;
          REG_ROUNDS_PER_BLOCK: block_rounds = cfg_wdata;
          REG_BLOCK_BYTES:      block_len    = cfg_wdata;
          REG_FINAL_ROUNDS:     final_rounds = cfg_wdata;
          REG_HASH_BYTES:       digest_len   = cfg_wdata[6:0];
          default:              hit          = 1'b0;
        endcase
        if (hit) rebuild_cube();
      end
      if (in_valid && in_ready) hash_item(chde_op_t'(in_command), in_data_byte);
    end
    mismatches    <= fail_total;
    expected_left <= digest_queue.size();
    digests_done  <= digest_total;
  end

endmodule

[tb/cubehash_digest_engine_tb.sv]
// ----------------------------------------------------------------------------
// CubeHash digest engine testbench
// Drives message and finish items into the engine under a series of
// register settings, from the reset values through both extremes of every
// register to random settings, with random gaps on the message side
// and random stalls on the digest side. The checker beside the engine
// predicts and compares every digest byte.
// ----------------------------------------------------------------------------
module cubehash_digest_engine_tb;
  import chde_pkg::*;

  localparam int CYCLE_LIMIT   = 2000000;
  localparam int SETTLE_CYCLES = 300;
  localparam int RANDOM_ITEMS  = 96;

  localparam logic [REG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [REG_IDX_W-1:0]  cfg_index;
  logic [REG_DATA_W-1:0] cfg_wdata;
  logic                  calm;
  int                    stall_left;
  int                    cycles = 0;
  int                    items_sent = 0;
  int                    reg_writes = 0;
  int                    mismatches;
  int                    expected_left;
  int                    digests_done;

  chde_in_if  in_ch ();
  chde_out_if out_ch ();

  cubehash_digest_engine i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  cubehash_digest_engine_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_command      (in_ch.command),
    .in_data_byte    (in_ch.data_byte),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_digest_byte (out_ch.digest_byte),
    .out_last_byte   (out_ch.last_byte),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .expected_left   (expected_left),
    .digests_done    (digests_done)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("cubehash_digest_engine_tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (calm || !rst_n) begin
      out_ch.ready <= 1'b1;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 11);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_item(chde_op_t op, logic [7:0] b);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= op;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_message(int unsigned len);
    repeat (len) send_item(OP_ABSORB, 8'($urandom_range(0, 255)));
    send_item(OP_FINISH, 8'($urandom_range(0, 255)));
  endtask

  // The pause lets the engine finish queued bytes and rebuild its cube.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_left != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [REG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    reg_writes++;
  endtask

  initial begin
    int          directed_items;
    int unsigned blk;
    int unsigned cap;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.command   = OP_ABSORB;
    in_ch.data_byte = '0;
    out_ch.ready    = 1'b0;
    calm            = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: an empty message, then a two-byte message.
    send_item(OP_FINISH, 8'hA5);
    send_item(OP_ABSORB, 8'h00);
    send_item(OP_ABSORB, 8'hFF);
    send_item(OP_FINISH, 8'h00);
    drain();

    // Zero rounds everywhere, block length zero and a digest length that
    // masks to zero.
    write_reg(REG_INIT_ROUNDS, 8'd0);
    write_reg(REG_ROUNDS_PER_BLOCK, 8'd0);
    write_reg(REG_FINAL_ROUNDS, 8'd0);
    write_reg(REG_BLOCK_BYTES, 8'd0);
    write_reg(REG_HASH_BYTES, 8'h80);
    send_item(OP_ABSORB, 8'h00);
    send_item(OP_ABSORB, 8'hFF);
    send_item(OP_FINISH, 8'h00);
    send_item(OP_FINISH, 8'hFF);
    drain();

    // Maximum rounds, block length above the limit and a digest length
    // that masks above the limit.
    write_reg(REG_INIT_ROUNDS, 8'd255);
    write_reg(REG_ROUNDS_PER_BLOCK, 8'd255);
    write_reg(REG_FINAL_ROUNDS, 8'd255);
    write_reg(REG_BLOCK_BYTES, 8'hFF);
    write_reg(REG_HASH_BYTES, 8'hFF);
    send_item(OP_ABSORB, 8'h5A);
    send_item(OP_FINISH, 8'h00);
    drain();

    // Exactly one full block, then unused register indexes and a real
    // register write in the middle of a message.
    write_reg(REG_INIT_ROUNDS, 8'd3);
    write_reg(REG_ROUNDS_PER_BLOCK, 8'd1);
    write_reg(REG_FINAL_ROUNDS, 8'd2);
    write_reg(REG_BLOCK_BYTES, 8'd4);
    write_reg(REG_HASH_BYTES, 8'd64);
    send_message(4);
    repeat (3) send_item(OP_ABSORB, 8'($urandom_range(0, 255)));
    drain();
    write_reg(REG_UNUSED_LO, 8'hFF);
    write_reg(REG_UNUSED_HI, 8'h00);
    send_message(1);
    repeat (2) send_item(OP_ABSORB, 8'($urandom_range(0, 255)));
    drain();
    write_reg(REG_FINAL_ROUNDS, 8'd3);
    send_item(OP_FINISH, 8'h3C);
    drain();

    directed_items = items_sent;
    while (items_sent - directed_items < RANDOM_ITEMS) begin
      if (items_sent - directed_items >= RANDOM_ITEMS * 3 / 4) calm <= 1'b1;
      blk = ($urandom_range(0, 7) == 0) ? 128 : $urandom_range(0, 12);
      write_reg(REG_INIT_ROUNDS, 8'($urandom_range(0, 24)));
      write_reg(REG_ROUNDS_PER_BLOCK, 8'($urandom_range(0, 24)));
      write_reg(REG_BLOCK_BYTES, 8'(blk));
      write_reg(REG_FINAL_ROUNDS, 8'($urandom_range(0, 40)));
      write_reg(REG_HASH_BYTES, 8'($urandom_range(0, 255)));
      cap = (blk == 0) ? 4 : 2 * blk + 2;
      if (cap > 30) cap = 30;
      repeat ($urandom_range(2, 4)) begin
        if (items_sent - directed_items < RANDOM_ITEMS) begin
          send_message(($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, cap));
        end
      end
      drain();
    end

    $display("Run covered %0d items (%0d directed) over %0d register writes.",
             items_sent, directed_items, reg_writes);
    $display("The checker compared %0d complete digests.", digests_done);
    if (mismatches == 0 && expected_left == 0) begin
      $display("cubehash_digest_engine_tb passed");
    end else begin
      $display("cubehash_digest_engine_tb failed");
    end
    $finish;
  end

endmodule
